@@ design/x64ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// x64ptw_pkg
// Shared types and codes for the four-level page table walker: transaction
// payloads, field codes, register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package x64ptw_pkg;

	// Widths of the payload fields.
	localparam int unsigned AddrW  = 48;
	localparam int unsigned EntryW = 64;
	localparam int unsigned LevelW = 3;
	localparam int unsigned StatW  = 3;
	localparam int unsigned CfgIdxW = 2;

	// Input transaction kinds.
	localparam logic KIND_REQ  = 1'b0;
	localparam logic KIND_RESP = 1'b1;

	// Result kinds.
	localparam logic RK_READ = 1'b0;
	localparam logic RK_DONE = 1'b1;

	// Completion status codes.
	localparam logic [StatW-1:0] STAT_OK        = 3'd0;
	localparam logic [StatW-1:0] STAT_NOT_PRES  = 3'd1;
	localparam logic [StatW-1:0] STAT_SUPER     = 3'd2;
	localparam logic [StatW-1:0] STAT_RESERVED  = 3'd3;
	localparam logic [StatW-1:0] STAT_TOP_LARGE = 3'd4;
	localparam logic [StatW-1:0] STAT_READ_FAIL = 3'd5;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_ROOT_BASE   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_USER_ONLY   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_START_LEVEL = 2'd2;

	// Levels of the table hierarchy.
	localparam logic [LevelW-1:0] LVL_PT   = 3'd1;
	localparam logic [LevelW-1:0] LVL_PD   = 3'd2;
	localparam logic [LevelW-1:0] LVL_PDPT = 3'd3;
	localparam logic [LevelW-1:0] LVL_TOP  = 3'd4;

	// Entry bit positions.
	localparam int unsigned BIT_PRESENT = 0;
	localparam int unsigned BIT_USER    = 2;
	localparam int unsigned BIT_LARGE   = 7;

	typedef struct packed {
		logic              kind;
		logic [AddrW-1:0]  virt_addr;
		logic [EntryW-1:0] entry_data;
		logic              read_ok;
	} ptw_in_t;

	typedef struct packed {
		logic              result_kind;
		logic [AddrW-1:0]  read_addr;
		logic [StatW-1:0]  status;
		logic [AddrW-1:0]  phys_addr;
		logic [EntryW-1:0] raw_entry;
	} ptw_out_t;

	typedef enum logic {
		WS_IDLE,
		WS_WALK
	} walk_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;     // latch a new address and issue the first read
		logic check;     // evaluate the entry of a read response
		logic load_out;  // capture the result into the output register
	} ptw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic finish;    // the checked entry ends the walk
	} ptw_sts_t;

endpackage

@@ design/x64ptw_ctrl.sv @@
// ----------------------------------------------------------------------------
// x64ptw_ctrl
// Walk controller: tracks whether a walk is in progress, decides which
// transactions are taken up and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module x64ptw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output x64ptw_pkg::ptw_cmd_t cmd,
	input  x64ptw_pkg::ptw_sts_t sts
);
	import x64ptw_pkg::*;

	walk_state_t state_q;
	walk_state_t state_d;
	logic        out_valid_q;
	logic        accept;

	// The result register frees up when its transaction is taken.
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			WS_IDLE: begin
				if (accept && in_kind == KIND_REQ) begin
					state_d = WS_WALK;
				end
			end
			WS_WALK: begin
				if (accept && in_kind == KIND_RESP && sts.finish) begin
					state_d = WS_IDLE;
				end
			end
			default: state_d = WS_IDLE;
		endcase
	end

	// Commands. A request during a walk and a response while idle are dropped.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			WS_IDLE: begin
				cmd.start = accept && in_kind == KIND_REQ;
			end
			WS_WALK: begin
				cmd.check = accept && in_kind == KIND_RESP;
			end
			default: cmd = '0;
		endcase
		cmd.load_out = cmd.start || cmd.check;
	end

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= WS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/x64ptw_dp.sv @@
// ----------------------------------------------------------------------------
// x64ptw_dp
// Walk datapath: configuration registers, the latched virtual address and
// current level, the entry checks, address formation and result register.
// ----------------------------------------------------------------------------
module x64ptw_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [x64ptw_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [x64ptw_pkg::AddrW-1:0]          cfg_wdata,
	input  x64ptw_pkg::ptw_in_t                   in_data,
	output x64ptw_pkg::ptw_out_t                  out_data,
	input  x64ptw_pkg::ptw_cmd_t                  cmd,
	output x64ptw_pkg::ptw_sts_t                  sts
);
	import x64ptw_pkg::*;

	logic [AddrW-1:0]  root_base_q;
	logic              user_only_q;
	logic [LevelW-1:0] start_level_q;
	logic [LevelW-1:0] level_q;
	logic [AddrW-1:0]  vaddr_q;
	ptw_out_t          out_q;

	logic [LevelW-1:0] lv;
	logic [LevelW-1:0] first_lv;
	logic [LevelW-1:0] next_lv;
	logic [EntryW-1:0] pte;
	ptw_out_t          req_res;
	ptw_out_t          resp_res;
	logic              resp_done;

	// Levels outside one to four start at the top.
	function automatic logic [LevelW-1:0] clamp_level(input logic [LevelW-1:0] l);
		logic [LevelW-1:0] r;
		r = LVL_TOP;
		if (l >= LVL_PT && l <= LVL_TOP) begin
			r = l;
		end
		return r;
	endfunction

	// Address of the entry for a table base, a virtual address and a level.
	function automatic logic [AddrW-1:0] entry_addr(input logic [AddrW-1:0] tbl,
			input logic [AddrW-1:0] va, input logic [LevelW-1:0] l);
		logic [8:0] idx;
		unique case (l)
			LVL_PT:   idx = va[20:12];
			LVL_PD:   idx = va[29:21];
			LVL_PDPT: idx = va[38:30];
			default:  idx = va[47:39];
		endcase
		return {tbl[AddrW-1:12], idx, 3'b000};
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_base_q   <= '0;
			user_only_q   <= 1'b0;
			start_level_q <= LVL_TOP;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ROOT_BASE:   root_base_q   <= cfg_wdata;
				CFG_USER_ONLY:   user_only_q   <= cfg_wdata[0];
				CFG_START_LEVEL: start_level_q <= cfg_wdata[LevelW-1:0];
				default: ;
			endcase
		end
	end

	// Request: the first entry read at the starting level.
	always_comb begin
		first_lv = clamp_level(start_level_q);
		req_res             = '0;
		req_res.result_kind = RK_READ;
		req_res.read_addr   = entry_addr(root_base_q, in_data.virt_addr, first_lv);
	end

	// Response: checks in priority order, then a leaf or a descent.
	always_comb begin
		lv        = clamp_level(level_q);
		pte       = in_data.entry_data;
		next_lv   = lv - LevelW'(1);
		resp_res  = '0;
		resp_res.result_kind = RK_DONE;
		resp_done = 1'b1;
		if (!in_data.read_ok) begin
			resp_res.status = STAT_READ_FAIL;
		end else if (!pte[BIT_PRESENT]) begin
			resp_res.status = STAT_NOT_PRES;
			if (lv == LVL_PT) begin
				resp_res.raw_entry = pte;
			end
		end else if (user_only_q && !pte[BIT_USER]) begin
			resp_res.status = STAT_SUPER;
		end else if (|pte[51:48]) begin
			resp_res.status = STAT_RESERVED;
		end else if (lv == LVL_PT || pte[BIT_LARGE]) begin
			if (lv == LVL_TOP) begin
				resp_res.status = STAT_TOP_LARGE;
			end else begin
				resp_res.status = STAT_OK;
				unique case (lv)
					LVL_PT:  resp_res.phys_addr = {pte[47:12], vaddr_q[11:0]};
					LVL_PD:  resp_res.phys_addr = {pte[47:21], vaddr_q[20:0]};
					default: resp_res.phys_addr = {pte[47:30], vaddr_q[29:0]};
				endcase
			end
		end else begin
			resp_done            = 1'b0;
			resp_res             = '0;
			resp_res.result_kind = RK_READ;
			resp_res.read_addr   = entry_addr(pte[AddrW-1:0], vaddr_q, next_lv);
		end
	end

	assign sts.finish = resp_done;

	// Walk state: latched address and current level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			vaddr_q <= '0;
		end else if (cmd.start) begin
			level_q <= first_lv;
			vaddr_q <= in_data.virt_addr;
		end else if (cmd.check && !resp_done) begin
			level_q <= next_lv;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= cmd.start ? req_res : resp_res;
		end
	end

	assign out_data = out_q;

endmodule

@@ design/x64_page_table_walker.sv @@
// ----------------------------------------------------------------------------
// x64_page_table_walker
// Four-level long-mode page table walker. Requests start a walk and each
// entry read response is checked, answered with the next read or the result.
// ----------------------------------------------------------------------------
// Timing: a result stands in the output register in the cycle after its input
// transaction is accepted; the checks of one entry are combinational.
// Throughput: one input transaction per cycle while results are taken; the
// single output register sets this figure. A walk spans up to four reads.
// Reset: arst_n clears the walk state and the result valid flag at once and
// sets the registers to base 0, user-only off and start level 4.
module x64_page_table_walker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [x64ptw_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [x64ptw_pkg::AddrW-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  x64ptw_pkg::ptw_in_t            in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output x64ptw_pkg::ptw_out_t           out_data
);
	import x64ptw_pkg::*;

	ptw_cmd_t cmd;
	ptw_sts_t sts;

	// Walk controller.
	x64ptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Walk datapath.
	x64ptw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-level page table walker. One sender
// process plays both the translation client and the memory: it offers
// translate requests and table entry read responses shaped from the
// predicted walk state. A scoreboard predicts each entry read and each
// finished translation, and compares every result transaction field by
// field. The walk settings change between phases while the walker is idle.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import x64ptw_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned ITEMS_PER_RUN = 100;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned HOLD_CYCLES   = 240;
	localparam int unsigned RSVD_LO       = 48;
	localparam int unsigned RSVD_HI       = 51;

	// Predicts the walker and keeps the results still to arrive.
	class walk_scoreboard;
		logic [AddrW-1:0]  root_base;
		logic              user_only;
		logic [LevelW-1:0] start_level;
		logic              walking;
		logic [LevelW-1:0] level;
		logic [AddrW-1:0]  vaddr;
		ptw_out_t          expected_results[$];
		int unsigned       errors;

		function new();
			root_base   = '0;
			user_only   = 1'b0;
			start_level = LVL_TOP;
			walking     = 1'b0;
			level       = '0;
			vaddr       = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] data);
			case (idx)
				CFG_ROOT_BASE:   root_base = data;
				CFG_USER_ONLY:   user_only = data[0];
				CFG_START_LEVEL: start_level = data[LevelW-1:0];
				default: ;
			endcase
		endfunction

		// Levels outside one to four start at the top.
		function logic [LevelW-1:0] walk_start(logic [LevelW-1:0] lv);
			return (lv >= LVL_PT && lv <= LVL_TOP) ? lv : LVL_TOP;
		endfunction

		function int unsigned index_shift(logic [LevelW-1:0] lv);
			return 12 + 9 * (int'(lv) - 1);
		endfunction

		// Entry address: table frame, nine index bits of this level, times eight.
		function ptw_out_t entry_read(logic [AddrW-1:0] tbl, logic [LevelW-1:0] lv);
			ptw_out_t r;
			logic [AddrW-1:0] sh;
			r = '0;
			sh = vaddr >> index_shift(lv);
			r.result_kind = RK_READ;
			r.read_addr = {tbl[AddrW-1:12], sh[8:0], 3'b000};
			return r;
		endfunction

		// Notes an accepted input transaction; returns 1 when a result follows.
		function bit note_input(ptw_in_t t);
			ptw_out_t r;
			logic [LevelW-1:0] lv;
			logic [AddrW-1:0] keep;
			r = '0;
			if (t.kind == KIND_REQ) begin
				if (walking)
					return 1'b0;
				vaddr = t.virt_addr;
				level = walk_start(start_level);
				walking = 1'b1;
				expected_results.push_back(entry_read(root_base, level));
				return 1'b1;
			end
			if (!walking)
				return 1'b0;
			lv = level;
			r.result_kind = RK_DONE;
			if (!t.read_ok) begin
				r.status = STAT_READ_FAIL;
			end else if (!t.entry_data[BIT_PRESENT]) begin
				r.status = STAT_NOT_PRES;
				if (lv == LVL_PT)
					r.raw_entry = t.entry_data;
			end else if (user_only && !t.entry_data[BIT_USER]) begin
				r.status = STAT_SUPER;
			end else if (t.entry_data[RSVD_HI:RSVD_LO] != '0) begin
				r.status = STAT_RESERVED;
			end else if (lv == LVL_PT || t.entry_data[BIT_LARGE]) begin
				if (lv == LVL_TOP) begin
					r.status = STAT_TOP_LARGE;
				end else begin
					keep = {AddrW{1'b1}} << index_shift(lv);
					r.status = STAT_OK;
					r.phys_addr = (t.entry_data[AddrW-1:0] & keep) | (vaddr & ~keep);
				end
			end else begin
				// A table entry: descend and fetch from the next table.
				level = lv - 1'b1;
				expected_results.push_back(entry_read(t.entry_data[AddrW-1:0], level));
				return 1'b1;
			end
			walking = 1'b0;
			expected_results.push_back(r);
			return 1'b1;
		endfunction

		function void compare(string name, logic [EntryW-1:0] want, logic [EntryW-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ptw_out_t got);
			ptw_out_t want;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare("result_kind", EntryW'(want.result_kind), EntryW'(got.result_kind));
			compare("read_addr", EntryW'(want.read_addr), EntryW'(got.read_addr));
			compare("status", EntryW'(want.status), EntryW'(got.status));
			compare("phys_addr", EntryW'(want.phys_addr), EntryW'(got.phys_addr));
			compare("raw_entry", want.raw_entry, got.raw_entry);
		endfunction

		function void close();
			if (expected_results.size() != 0) begin
				$error("%0d results never arrived", expected_results.size());
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = CFG_ROOT_BASE;
	logic [AddrW-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ptw_in_t             in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ptw_out_t            out_data;

	walk_scoreboard      book;
	bit                  idling_on = 1'b1;
	bit                  hold_off_request = 1'b0;
	int unsigned         walk_results = 0;

	x64_page_table_walker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [AddrW-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[AddrW-1:0];
	endfunction

	function automatic logic [EntryW-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic ptw_in_t make_req(logic [AddrW-1:0] va);
		ptw_in_t t;
		t.kind = KIND_REQ;
		t.virt_addr = va;
		t.entry_data = rand64();
		t.read_ok = 1'($urandom_range(0, 1));
		return t;
	endfunction

	function automatic ptw_in_t make_resp(logic [EntryW-1:0] entry, logic ok);
		ptw_in_t t;
		t.kind = KIND_RESP;
		t.virt_addr = rand48();
		t.entry_data = entry;
		t.read_ok = ok;
		return t;
	endfunction

	// Mostly a valid table entry; sometimes a leaf or one of the faults.
	function automatic logic [EntryW-1:0] make_entry();
		logic [EntryW-1:0] e;
		int unsigned roll;
		e = rand64();
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return e;
		e[RSVD_HI:RSVD_LO] = '0;
		e[BIT_PRESENT] = 1'b1;
		e[BIT_USER] = 1'b1;
		e[BIT_LARGE] = 1'b0;
		if (roll < 9)
			e[BIT_PRESENT] = 1'b0;
		else if (roll < 14)
			e[BIT_USER] = 1'b0;
		else if (roll < 19)
			e[RSVD_HI:RSVD_LO] = 4'($urandom_range(1, 15));
		else if (roll < 37)
			e[BIT_LARGE] = 1'b1;
		return e;
	endfunction

	// Picks the next transaction from the predicted walk state.
	function automatic ptw_in_t next_item(bit finish_walk);
		int unsigned roll;
		logic [AddrW-1:0] va;
		roll = $urandom_range(0, 99);
		if (book.walking && (finish_walk || roll >= 6))
			return make_resp(make_entry(), 1'($urandom_range(0, 24) != 0));
		if (!book.walking && roll < 8)
			return make_resp(rand64(), 1'($urandom_range(0, 1)));
		va = rand48();
		if (roll >= 96)
			va = '1;
		else if (roll >= 93)
			va = '0;
		return make_req(va);
	endfunction

	// Offers one transaction and waits for it to be taken.
	task automatic offer(input ptw_in_t t);
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		if (book.note_input(t))
			walk_results++;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Completes any walk in progress and lets every result drain.
	task automatic settle();
		while (book.walking)
			offer(next_item(1'b1));
		in_valid <= 1'b0;
		while (book.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_one(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		book.set_reg(idx, data);
	endtask

	// Writes all three registers; unused upper data bits carry noise.
	task automatic load_config(input logic [AddrW-1:0] base, input logic uo,
			input logic [LevelW-1:0] sl);
		logic [AddrW-1:0] noise;
		noise = rand48();
		write_one(CFG_ROOT_BASE, base);
		write_one(CFG_USER_ONLY, {noise[AddrW-1:1], uo});
		write_one(CFG_START_LEVEL, {noise[AddrW-1:LevelW], sl});
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				book.check_result(out_data);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL x64_page_table_walker");
		$finish;
	end

	initial begin : stimulus
		ptw_in_t directed[$];
		logic [EntryW-1:0] tbl_entry;
		logic [EntryW-1:0] big_leaf;
		logic [AddrW-1:0] base;
		logic uo;
		logic [LevelW-1:0] sl;
		int unsigned goal;
		book = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walks with the top base, user-only on and a four-level start.
		load_config('1, 1'b1, LVL_TOP);
		tbl_entry = 64'h8000_0ABC_DEF0_1027;
		big_leaf = 64'h7FF0_FFFF_FFFF_FFFF;
		directed.push_back(make_resp(tbl_entry, 1'b1));
		// A 1 GB page, with a request ignored mid-walk.
		directed.push_back(make_req('1));
		directed.push_back(make_req('0));
		directed.push_back(make_resp(tbl_entry, 1'b1));
		directed.push_back(make_resp(big_leaf, 1'b1));
		// A 2 MB page.
		directed.push_back(make_req('0));
		directed.push_back(make_resp(tbl_entry, 1'b1));
		directed.push_back(make_resp(tbl_entry, 1'b1));
		directed.push_back(make_resp(big_leaf, 1'b1));
		// A 4 KB page through all four levels.
		directed.push_back(make_req(48'hAAAA_5555_AAAA));
		repeat (3) directed.push_back(make_resp(tbl_entry, 1'b1));
		directed.push_back(make_resp(64'h0000_0000_0000_1005, 1'b1));
		// A missing 4 KB page, whose raw entry is returned.
		directed.push_back(make_req(48'h1234_5678_9ABC));
		repeat (3) directed.push_back(make_resp(tbl_entry, 1'b1));
		directed.push_back(make_resp(64'hFFFF_FFFF_FFFF_FFFE, 1'b1));
		// Faults at the top: not present, supervisor, reserved, large, read failure.
		directed.push_back(make_req(rand48()));
		directed.push_back(make_resp(64'hFFFF_FFFF_FFFF_FFFE, 1'b1));
		directed.push_back(make_req(rand48()));
		directed.push_back(make_resp(64'h0000_0000_0000_0001, 1'b1));
		directed.push_back(make_req(rand48()));
		directed.push_back(make_resp(64'h000F_0000_0000_0005, 1'b1));
		directed.push_back(make_req(rand48()));
		directed.push_back(make_resp(64'h0000_0000_0000_0085, 1'b1));
		directed.push_back(make_req(rand48()));
		directed.push_back(make_resp('1, 1'b0));
		foreach (directed[i])
			offer(directed[i]);
		settle();

		// Random phases, each under its own settings.
		for (int p = 0; p < PHASES; p++) begin
			base = rand48();
			uo = 1'(p % 2);
			case (p)
				0: sl = LVL_TOP;
				1: begin
					sl = LVL_PDPT;
					base = '0;
				end
				2: begin
					sl = LVL_PD;
					base = '1;
				end
				3: sl = LVL_PT;
				4: sl = 3'd0;
				5: sl = 3'd5;
				6: sl = 3'd6;
				default: sl = 3'd7;
			endcase
			load_config(base, uo, sl);
			idling_on = !(p == 3 || p == PHASES - 1);
			if (p == 1)
				hold_off_request = 1'b1;
			goal = walk_results + ITEMS_PER_RUN;
			while (walk_results < goal)
				offer(next_item(1'b0));
			settle();
		end

		book.close();
		if (book.errors == 0)
			$display("PASS x64_page_table_walker");
		else
			$display("FAIL x64_page_table_walker");
		$finish;
	end

endmodule
